FILE: src/mec_pkg.sv
// Shared types, fixed-point constants and helpers for the Mandelbrot escape counter.
package mec_pkg;

  // Fixed-point format of c and z.
  localparam int FracBits = 28;
  // z width after clamping to +-(2.0 + 1 lsb).
  localparam int ZW = FracBits + 3;
  // Exact product width.
  localparam int PW = 2 * ZW;
  // Width of the shifted products and their sums.
  localparam int SW = ZW + 5;

  localparam logic signed [SW-1:0] TwoVal  = SW'(64'sd1 <<< (FracBits + 1));
  localparam logic signed [SW-1:0] FourVal = SW'(64'sd1 <<< (FracBits + 2));

  typedef logic signed [ZW-1:0] zval_t;
  typedef logic signed [SW-1:0] sval_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef struct packed {
    logic load;      // capture c, start z = clamp(c)
    logic mul;       // register the three products
    logic step;      // advance z and the pass count
    logic out_load;  // move the pass count into the result register
  } mec_cmd_t;

  typedef struct packed {
    logic cont;      // another pass is due
  } mec_stat_t;

  // Clamp a component to +-(2.0 + 1 lsb); its square then still exceeds 4.0.
  function automatic zval_t mec_clamp(sval_t v);
    zval_t r;
    if (v > TwoVal) begin
      r = ZW'(TwoVal + sval_t'(1));
    end else if (v < -TwoVal) begin
      r = ZW'(-(TwoVal + sval_t'(1)));
    end else begin
      r = v[ZW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/mec_datapath.sv
// Datapath of the escape counter: z registers, product registers, pass counter.
module mec_datapath #(
  parameter int COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  mec_pkg::mec_cmd_t  cmd_i,
  output mec_pkg::mec_stat_t stat_o,
  input  logic signed [31:0] c_real_i,
  input  logic signed [31:0] c_imag_i,
  input  logic [15:0]        max_iterations_i,
  output logic [15:0]        escape_count_o
);
  import mec_pkg::*;

  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_BITS) - 64'd1);

  logic signed [31:0]    cr_q, ci_q;
  zval_t                 zr_q, zi_q;
  prod_t                 prr_q, pii_q, pri_q;
  logic [COUNT_BITS-1:0] count_q, bound_q;
  logic [15:0]           res_q;

  sval_t       dr, di, nr, ni, mag;
  logic [31:0] bound_ext, count_ext;

  // Loop bound: max_iterations - 1, zero for a bound of one or less, saturated.
  always_comb begin
    if (max_iterations_i > 16'd1) begin
      bound_ext = 32'(max_iterations_i) - 32'd1;
    end else begin
      bound_ext = 32'd0;
    end
    if (bound_ext > CountMax) begin
      bound_ext = CountMax;
    end
  end

  // Arithmetic shift of an exact product is floor division.
  assign dr  = SW'(prr_q >>> FracBits);
  assign di  = SW'(pii_q >>> FracBits);
  assign mag = dr + di;
  assign nr  = dr - di + SW'(cr_q);
  assign ni  = SW'(pri_q >>> (FracBits - 1)) + SW'(ci_q);

  assign stat_o.cont = (count_q < bound_q) && (mag <= FourVal);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cr_q    <= c_real_i;
      ci_q    <= c_imag_i;
      zr_q    <= mec_clamp(SW'(c_real_i));
      zi_q    <= mec_clamp(SW'(c_imag_i));
      count_q <= '0;
      bound_q <= bound_ext[COUNT_BITS-1:0];
    end else if (cmd_i.step) begin
      zr_q    <= mec_clamp(nr);
      zi_q    <= mec_clamp(ni);
      count_q <= count_q + COUNT_BITS'(1);
    end
    if (cmd_i.mul) begin
      prr_q <= zr_q * zr_q;
      pii_q <= zi_q * zi_q;
      pri_q <= zr_q * zi_q;
    end
  end

  assign count_ext = 32'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q <= count_ext[15:0];
    end
  end

  assign escape_count_o = res_q;

endmodule

FILE: src/mec_ctrl.sv
// Controller of the escape counter: sequences load, multiply and evaluate steps.
module mec_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mec_pkg::mec_cmd_t  cmd_o,
  input  mec_pkg::mec_stat_t stat_i
);
  import mec_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StEval = 2'd2;
  localparam logic [1:0] StHold = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StEval;
      end
      StEval: begin
        if (stat_i.cont) begin
          cmd_o.step = 1'b1;
          state_d    = StMul;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end else begin
          state_d = StHold;
        end
      end
      StHold: begin
        // hold the finished count until the result register frees up
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_then_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.mul)
    else $error("load not followed by multiply");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  a_step_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !cmd_o.out_load && !cmd_o.load)
    else $error("step issued together with load or result write");

  a_mul_then_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |=> !cmd_o.mul && !cmd_o.load)
    else $error("multiply not followed by an evaluate step");

endmodule

FILE: src/mandelbrot_escape_count.sv
// Top level of the Mandelbrot escape counter: config register, controller, datapath.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   c_real_i, c_imag_i
//   out      source     out_valid_o / out_stall_i escape_count_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_data_i (max_iterations)
//
// The result is registered after a multiply state and an evaluate state for each pass
// done and for the final test; the next point is accepted once the controller is back
// in idle. One point is in work at a time.
// Reset sets max_iterations to 256 and empties the result register.
// A stalled result sits in its register while the next point is accepted.
module mandelbrot_escape_count #(
  parameter int COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] c_real_i,
  input  logic signed [31:0] c_imag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        escape_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);
  import mec_pkg::*;

  mec_cmd_t    cmd;
  mec_stat_t   stat;
  logic [15:0] max_iter_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= 16'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_iter_q <= cfg_data_i;
    end
  end

  mec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  mec_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .c_real_i         (c_real_i),
    .c_imag_i         (c_imag_i),
    .max_iterations_i (max_iter_q),
    .escape_count_o   (escape_count_o)
  );

endmodule
